@@ rtl/positional_array_list_defines.svh @@
// Assertion macros used by the positional array list top level.
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define PAL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PAL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PAL_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define PAL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/pal_pkg.sv @@
// Types, constants and codes of the positional array list.
`default_nettype none

package pal_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;

    localparam int POS_W  = 5;
    localparam int OUT_W  = 32;
    localparam int OCNT_W = 5;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [2:0] {
        MODE_READ    = 3'd0,
        MODE_INSERT  = 3'd1,
        MODE_REPLACE = 3'd2,
        MODE_REMOVE  = 3'd3,
        MODE_CLEAR   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]        mode;
        logic [POS_W-1:0]  position;
        logic signed [31:0] value_in;
    } in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] read_word;
        logic [OCNT_W-1:0]       entry_count;
        logic [1:0]              status;
        logic                    is_empty;
    } out_t;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic             shift_up;
        logic             shift_down;
        logic             write;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
    } cell_cmd_t;

    // Outcome of one command as seen by the result register.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        status_t          status;
        logic             read_hit;
        logic             read_miss;
        logic [IDX_W-1:0] idx;
    } ctrl_res_t;

endpackage

`default_nettype wire

@@ rtl/positional_array_list.sv @@
// Top level of the positional array list: controller, cell chain and result register.
//
//   channel   direction   handshake                 word type
//   command   in          start, busy               pal_pkg::in_t  (cmd)
//   result    out         done (one-cycle strobe)   pal_pkg::out_t (result)
//
// A command word is taken at each rising edge where start is high and busy is
// low. busy is always low, so one command may be issued every cycle.
// The result word for a command is presented with done high in the very next
// cycle; the receiver has no way to hold it off.
// Reset clears the entry count and the result strobe. The stored words are not
// cleared; a word is only read back at a position that has been written.
// Clearing the list only resets the entry count.
`default_nettype none
`include "positional_array_list_defines.svh"

module positional_array_list (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire pal_pkg::in_t  cmd,
    output logic               done,
    output pal_pkg::out_t      result
);
    import pal_pkg::*;

    cell_cmd_t             cell_cmd;
    ctrl_res_t             res;
    logic                  go;
    logic [WORD_WIDTH-1:0] cell_word [DEPTH];
    logic [63:0]           val_wide;
    logic [WORD_WIDTH-1:0] wr_word;
    logic [63:0]           rd_wide;
    logic [OUT_W-1:0]      rd_word;

    logic                  done_reg;
    logic                  done_next;
    out_t                  result_reg;
    out_t                  result_next;

    // Every command completes at the edge where it is taken, so the block never reports busy.
    assign busy = 1'b0;
    assign go   = start && !busy;

    // Incoming words are kept in their low WORD_WIDTH bits.
    assign val_wide = 64'($unsigned(cmd.value_in));
    assign wr_word  = val_wide[WORD_WIDTH-1:0];

    pal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .cmd      (cmd),
        .cell_cmd (cell_cmd),
        .res      (res)
    );

    // The chain: each cell sees the words of both neighbors, so an insert
    // shifts the tail up by one place and a remove pulls it down by one place.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [WORD_WIDTH-1:0] left_w;
        logic [WORD_WIDTH-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = cell_word[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = cell_word[g+1];
        end

        pal_cell u_cell (
            .clk        (clk),
            .cell_idx   (IDX_W'(g)),
            .cmd        (cell_cmd),
            .wr_word    (wr_word),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[g])
        );
    end

    // A read picks its cell before the edge; the stored word is zero-extended
    // to the result width.
    assign rd_wide = 64'(cell_word[res.idx]);
    assign rd_word = rd_wide[OUT_W-1:0];

    always_comb
    begin
        result_next.read_word   = '0;
        if (res.read_hit)
        begin
            result_next.read_word = rd_word;
        end
        else if (res.read_miss)
        begin
            result_next.read_word = '1;
        end
        result_next.entry_count = OCNT_W'(res.count);
        result_next.status      = res.status;
        result_next.is_empty    = (res.count == '0);
        done_next               = go;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted command yields exactly one result in the next cycle.
    `PAL_ASSERT_NEXT(a_done_follows, clk, rst_n, go, done)
    `PAL_ASSERT_NEXT(a_no_spurious, clk, rst_n, !go, !done)
    // The empty flag agrees with the reported count.
    `PAL_ASSERT_NOW(a_empty_flag, clk, rst_n, done, result.is_empty == (result.entry_count == '0))
    // The count never exceeds the number of cells in the chain.
    `PAL_ASSERT_NOW(a_count_bound, clk, rst_n, go, res.count <= CNT_W'(DEPTH))
    // Only a read ever returns a nonzero word.
    `PAL_ASSERT_NOW(a_word_read_only, clk, rst_n, go && !res.read_hit && !res.read_miss, result_next.read_word == '0)

endmodule

`default_nettype wire

@@ rtl/pal_cell.sv @@
// One storage cell of the list chain.
`default_nettype none

module pal_cell (
    input  wire logic                           clk,
    input  wire logic [pal_pkg::IDX_W-1:0]      cell_idx,
    input  wire pal_pkg::cell_cmd_t             cmd,
    input  wire logic [pal_pkg::WORD_WIDTH-1:0] wr_word,
    input  wire logic [pal_pkg::WORD_WIDTH-1:0] left_word,
    input  wire logic [pal_pkg::WORD_WIDTH-1:0] right_word,
    output logic      [pal_pkg::WORD_WIDTH-1:0] word
);
    import pal_pkg::*;

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;
    logic [CNT_W-1:0]      my_pos;

    assign my_pos = CNT_W'(cell_idx);

    always_comb
    begin
        word_next = word_reg;
        if (cmd.write && (cell_idx == cmd.idx))
        begin
            word_next = wr_word;
        end
        else if (cmd.shift_up && (cell_idx > cmd.idx) && (my_pos <= cmd.cnt))
        begin
            word_next = left_word;
        end
        else if (cmd.shift_down && (cell_idx >= cmd.idx) && ((my_pos + 1'b1) < cmd.cnt))
        begin
            word_next = right_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

`default_nettype wire

@@ rtl/pal_ctrl.sv @@
// Command decode, entry count and status for the list chain.
`default_nettype none

module pal_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               go,
    input  wire pal_pkg::in_t       cmd,
    output pal_pkg::cell_cmd_t      cell_cmd,
    output pal_pkg::ctrl_res_t      res
);
    import pal_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic [CMP_W-1:0] pos_m1;
    logic             pos_nz;
    logic             in_rng;
    logic             ins_rng;
    logic             is_full;
    status_t          status;
    logic             up;
    logic             down;
    logic             wr;
    logic             hit;
    logic             miss;

    assign pos_c   = CMP_W'(cmd.position);
    assign cnt_c   = CMP_W'(count_reg);
    assign pos_m1  = pos_c - 1'b1;
    assign pos_nz  = (cmd.position != '0);
    assign in_rng  = pos_nz && (pos_c <= cnt_c);
    assign ins_rng = pos_nz && (pos_c <= (cnt_c + 1'b1));
    assign is_full = (cnt_c == CMP_W'(DEPTH));

    always_comb
    begin
        status     = ST_OK;
        count_next = count_reg;
        up         = 1'b0;
        down       = 1'b0;
        wr         = 1'b0;
        hit        = 1'b0;
        miss       = 1'b0;
        case (cmd.mode)
            MODE_READ:
            begin
                if (in_rng)
                begin
                    hit = 1'b1;
                end
                else
                begin
                    miss   = 1'b1;
                    status = ST_INVALID;
                end
            end
            MODE_INSERT:
            begin
                if (!ins_rng)
                begin
                    status = ST_INVALID;
                end
                else if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    up         = 1'b1;
                    wr         = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_REPLACE:
            begin
                if (in_rng)
                begin
                    wr = 1'b1;
                end
                else
                begin
                    status = ST_INVALID;
                end
            end
            MODE_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else if (!in_rng)
                begin
                    status = ST_INVALID;
                end
                else
                begin
                    down       = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            MODE_CLEAR:
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    count_next = '0;
                end
            end
            default:
            begin
                status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (go)
        begin
            count_reg <= count_next;
        end
    end

    assign cell_cmd.shift_up   = go && up;
    assign cell_cmd.shift_down = go && down;
    assign cell_cmd.write      = go && wr;
    assign cell_cmd.idx        = pos_m1[IDX_W-1:0];
    assign cell_cmd.cnt        = count_reg;

    assign res.count     = count_next;
    assign res.status    = status;
    assign res.read_hit  = hit;
    assign res.read_miss = miss;
    assign res.idx       = pos_m1[IDX_W-1:0];

endmodule

`default_nettype wire
